// ===== rtl/voice_effect_chain_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Voice effect chain assertion macros
// Shared property shapes for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef VOICE_EFFECT_CHAIN_UNIT_ASSERT_SVH
`define VOICE_EFFECT_CHAIN_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define VEC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define VEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vec_pkg.sv =====
// ---------------------------------------------------------------------------
// vec_pkg
// Types and fixed constants of the voice effect chain.
// ---------------------------------------------------------------------------
package vec_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_EFFECTS_ENABLE = 3'd0,
        REG_CARRIER_STEP   = 3'd1,
        REG_RING_MIX       = 3'd2,
        REG_CRUSH_BITS     = 3'd3,
        REG_CLIP_ENABLE    = 3'd4,
        REG_CLIP_LEVEL     = 3'd5,
        REG_OUTPUT_GAIN    = 3'd6
    } vec_reg_idx_t;

    // Register widths and reset values
    localparam int PHASE_W        = 32;
    localparam int RING_MIX_W     = 16;
    localparam int CRUSH_BITS_W   = 5;
    localparam int CLIP_LEVEL_W   = 15;
    localparam int GAIN_W         = 16;

    localparam logic [CLIP_LEVEL_W-1:0] CLIP_LEVEL_RESET = 15'h7FFF;
    localparam logic [GAIN_W-1:0]       GAIN_RESET       = 16'h1000;
    localparam logic [RING_MIX_W-1:0]   RING_MIX_FULL    = 16'h8000;

    typedef struct packed {
        logic                           effects_enable;
        logic [PHASE_W-1:0]             carrier_step;
        logic [RING_MIX_W-1:0]          ring_mix;
        logic [CRUSH_BITS_W-1:0]        crush_bits;
        logic                           clip_enable;
        logic [CLIP_LEVEL_W-1:0]        clip_limit;
        logic signed [GAIN_W-1:0]       gain_factor;
    } vec_cfg_t;

    // Sine table entries: unsigned Q0.15 magnitude
    localparam int TABLE_W = 15;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Digit-serial multiplier
    localparam int DIGIT_W    = 4;
    localparam int COEF_MAG_W = 31;   // |ring coefficient| <= 2^30
    localparam int RING_FRAC  = 30;
    localparam int GAIN_FRAC  = 12;

endpackage

// ===== rtl/vec_in_if.sv =====
// ---------------------------------------------------------------------------
// vec_in_if
// Sample request channel: valid/ready with input sample and utterance mark.
// ---------------------------------------------------------------------------
interface vec_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           first_sample;

    modport source (output valid, output sample_in, output first_sample, input ready);
    modport sink   (input valid, input sample_in, input first_sample, output ready);
endinterface

// ===== rtl/vec_out_if.sv =====
// ---------------------------------------------------------------------------
// vec_out_if
// Result request channel: valid/ready with the processed sample.
// ---------------------------------------------------------------------------
interface vec_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/vec_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// vec_cfg_regs
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
module vec_cfg_regs
    import vec_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output vec_cfg_t               cfg
);

    vec_cfg_t cfg_reg;
    vec_cfg_t cfg_next;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (vec_reg_idx_t'(cfg_index))
                REG_EFFECTS_ENABLE: cfg_next.effects_enable = cfg_data[0];
                REG_CARRIER_STEP:   cfg_next.carrier_step   = cfg_data[PHASE_W-1:0];
                REG_RING_MIX:       cfg_next.ring_mix       = cfg_data[RING_MIX_W-1:0];
                REG_CRUSH_BITS:     cfg_next.crush_bits     = cfg_data[CRUSH_BITS_W-1:0];
                REG_CLIP_ENABLE:    cfg_next.clip_enable    = cfg_data[0];
                REG_CLIP_LEVEL:     cfg_next.clip_limit     = cfg_data[CLIP_LEVEL_W-1:0];
                REG_OUTPUT_GAIN:    cfg_next.gain_factor    = $signed(cfg_data[GAIN_W-1:0]);
                default:            cfg_next = cfg_reg;   // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.effects_enable <= 1'b0;
            cfg_reg.carrier_step   <= '0;
            cfg_reg.ring_mix       <= '0;
            cfg_reg.crush_bits     <= '0;
            cfg_reg.clip_enable    <= 1'b0;
            cfg_reg.clip_limit     <= CLIP_LEVEL_RESET;
            cfg_reg.gain_factor    <= $signed(GAIN_RESET);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/vec_sine_rom.sv =====
// ---------------------------------------------------------------------------
// vec_sine_rom
// Quarter-wave sine ROM, DEPTH+1 entries, registered read.
// ---------------------------------------------------------------------------
module vec_sine_rom
    import vec_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic                         clk,
    input  logic [$clog2(DEPTH+1)-1:0]   addr,
    output logic [TABLE_W-1:0]           data
);

    typedef logic [TABLE_W-1:0] rom_t [DEPTH+1];

    // Entry k = round(32767 * sin(pi/2 * k / DEPTH)), Q30 Taylor series to x^13
    function automatic rom_t build_rom();
        rom_t               tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        e;
        logic signed [63:0] sum;
        for (int k = 0; k <= DEPTH; k++)
        begin
            x    = (64'(k) * HALF_PI_Q30) / 64'(DEPTH);
            x2   = (x * x) >> 30;
            sum  = $signed(x);
            term = ((x * x2) >> 30) / 64'd6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + $signed(term);
            if (sum < 0)
            begin
                sum = '0;
            end
            e = ((64'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
            if (e > 64'd32767)
            begin
                e = 64'd32767;
            end
            tab[k] = e[TABLE_W-1:0];
        end
        return tab;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [TABLE_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= SINE_ROM[addr];
    end

    assign data = data_reg;

endmodule

// ===== rtl/vec_serial_mul.sv =====
// ---------------------------------------------------------------------------
// vec_serial_mul
// Digit-serial unsigned multiplier: one multiplier digit per cycle,
// partial sums shift right through the product register.
// ---------------------------------------------------------------------------
module vec_serial_mul
    import vec_pkg::*;
#(
    parameter int MAG_W = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [MAG_W-1:0]            mplier,
    input  logic [COEF_MAG_W-1:0]       mcand,
    output logic                        busy,
    output logic [((MAG_W+DIGIT_W-1)/DIGIT_W)*DIGIT_W+COEF_MAG_W-1:0] product
);

    localparam int NDIG   = (MAG_W + DIGIT_W - 1) / DIGIT_W;
    localparam int LO_W   = NDIG * DIGIT_W;
    localparam int PROD_W = LO_W + COEF_MAG_W;
    localparam int SUM_W  = COEF_MAG_W + DIGIT_W;
    localparam int CNT_W  = $clog2(NDIG + 1);

    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     prod_next;
    logic [COEF_MAG_W-1:0] mcand_reg;
    logic [COEF_MAG_W-1:0] mcand_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [SUM_W-1:0]      partial;
    logic [SUM_W-1:0]      step_sum;

    // One digit step: high part plus digit times multiplicand
    assign partial  = SUM_W'(prod_reg[DIGIT_W-1:0]) * SUM_W'(mcand_reg);
    assign step_sum = SUM_W'(prod_reg[PROD_W-1:LO_W]) + partial;

    always_comb
    begin
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        if (start)
        begin
            prod_next  = {{COEF_MAG_W{1'b0}}, LO_W'(mplier)};
            mcand_next = mcand;
            cnt_next   = CNT_W'(NDIG);
        end
        else if (cnt_reg != '0)
        begin
            prod_next = {step_sum, prod_reg[LO_W-1:DIGIT_W]};
            cnt_next  = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
    end

    assign busy    = (cnt_reg != '0);
    assign product = prod_reg;

endmodule

// ===== rtl/voice_effect_chain_unit.sv =====
// ---------------------------------------------------------------------------
// voice_effect_chain_unit
// Ring modulator, bitcrusher, hard clipper and output gain on Q1.15 audio.
// ---------------------------------------------------------------------------
// One sample is worked on at a time, kept as sign and magnitude. With the
// chain disabled a sample goes from acceptance straight to the output
// state; enabled, it passes the ring modulation steps when active, then
// crush, clip and gain. Processing time is set by the 4-bit digit-serial
// multiplier, used once for the ring coefficient and once for the gain,
// and by the registered sine ROM read. The next sample is taken while a
// finished result still waits in the output register. Configuration must
// be written by the user only while the block is idle; the block does
// not enforce it. The carrier phase restarts on first_sample and advances
// by carrier_step for every sample, enabled or not.
// ---------------------------------------------------------------------------
module voice_effect_chain_unit
    import vec_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_WIDTH     = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    vec_in_if.sink                 sample_chan,
    vec_out_if.source              result_chan,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int FRAC_W  = SAMPLE_WIDTH - 1;
    localparam int NDIG    = (SAMPLE_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int PROD_W  = NDIG * DIGIT_W + COEF_MAG_W;
    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int IPROD_W = 30 + IDX_W;
    localparam int ROM_AW  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int GQ_W    = PROD_W - GAIN_FRAC;

    localparam logic [SAMPLE_WIDTH-1:0] ONE_MAG = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [SAMPLE_WIDTH-1:0] MAX_POS = {1'b0, {FRAC_W{1'b1}}};

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_ADDR  = 11'b000_0000_0010,
        S_ROM   = 11'b000_0000_0100,
        S_COEF  = 11'b000_0000_1000,
        S_ABS   = 11'b000_0001_0000,
        S_RMUL  = 11'b000_0010_0000,
        S_CRUSH = 11'b000_0100_0000,
        S_CLIP  = 11'b000_1000_0000,
        S_GAIN  = 11'b001_0000_0000,
        S_GMUL  = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    vec_cfg_t cfg;

    state_t                   state_reg, state_next;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic [PHASE_W-1:0]       ph_reg, ph_next;
    logic [SAMPLE_WIDTH-1:0]  mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [ROM_AW-1:0]        rom_addr_reg, rom_addr_next;
    logic signed [33:0]       cm_reg, cm_next;
    logic                     out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0]  out_data_reg, out_data_next;

    // Configuration registers
    vec_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sine ROM
    logic [TABLE_W-1:0] tab_data;

    vec_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk  (clk),
        .addr (rom_addr_reg),
        .data (tab_data)
    );

    // Shared digit-serial multiplier
    logic                   mul_start;
    logic [COEF_MAG_W-1:0]  mul_mcand;
    logic                   mul_busy;
    logic [PROD_W-1:0]      mul_product;

    vec_serial_mul #(
        .MAG_W (SAMPLE_WIDTH)
    ) u_serial_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mplier  (mag_reg),
        .mcand   (mul_mcand),
        .busy    (mul_busy),
        .product (mul_product)
    );

    // Carrier table address from phase
    logic [IPROD_W-1:0] idx_prod;
    logic [IDX_W-1:0]   idx;

    assign idx_prod = IPROD_W'(ph_reg[29:0]) * IPROD_W'(SINE_TABLE_DEPTH);
    assign idx      = idx_prod[30 +: IDX_W];

    // Ring coefficient: 32768*(32768-m) + c*m
    logic [RING_MIX_W-1:0]  mix_eff;
    logic signed [16:0]     carrier_val;
    logic signed [33:0]     coef;
    logic [33:0]            coef_abs;
    logic                   coef_neg;

    assign mix_eff     = (cfg.ring_mix > RING_MIX_FULL) ? RING_MIX_FULL : cfg.ring_mix;
    assign carrier_val = ph_reg[31] ? -$signed({2'b00, tab_data}) : $signed({2'b00, tab_data});
    assign coef        = $signed(34'({RING_MIX_FULL - mix_eff, 15'b0})) + cm_reg;
    assign coef_neg    = coef[33];
    assign coef_abs    = coef_neg ? 34'(-coef) : 34'(coef);

    // Gain magnitude and sign
    logic                   gain_neg;
    logic [GAIN_W-1:0]      gain_abs;

    assign gain_neg = cfg.gain_factor[GAIN_W-1];
    assign gain_abs = gain_neg ? GAIN_W'(-cfg.gain_factor) : GAIN_W'(cfg.gain_factor);

    // Rounding of the products, half away from zero on the magnitude
    logic [PROD_W-1:0]       ring_sum;
    logic [PROD_W-1:0]       gain_sum;
    logic [GQ_W-1:0]         gain_q;
    logic [SAMPLE_WIDTH-1:0] ring_mag;
    logic [SAMPLE_WIDTH-1:0] gain_mag;

    assign ring_sum = mul_product + (PROD_W'(1) << (RING_FRAC - 1));
    assign ring_mag = ring_sum[RING_FRAC +: SAMPLE_WIDTH];
    assign gain_sum = mul_product + (PROD_W'(1) << (GAIN_FRAC - 1));
    assign gain_q   = gain_sum[PROD_W-1:GAIN_FRAC];
    assign gain_mag = (gain_q > GQ_W'(ONE_MAG)) ? ONE_MAG : gain_q[SAMPLE_WIDTH-1:0];

    // Bitcrush: keep crush_bits bits, round, saturate at +/-1
    logic                     crush_active;
    logic [CRUSH_BITS_W-1:0]  crush_sh;
    logic [SAMPLE_WIDTH:0]    crush_half;
    logic [SAMPLE_WIDTH:0]    crush_mask;
    logic [SAMPLE_WIDTH:0]    crush_t;
    logic [SAMPLE_WIDTH-1:0]  crush_mag;

    assign crush_active = (cfg.crush_bits != '0) && (cfg.crush_bits <= CRUSH_BITS_W'(FRAC_W));
    assign crush_sh     = CRUSH_BITS_W'(SAMPLE_WIDTH) - cfg.crush_bits;
    assign crush_half   = (SAMPLE_WIDTH+1)'(1) << (crush_sh - CRUSH_BITS_W'(1));
    assign crush_mask   = {(SAMPLE_WIDTH+1){1'b1}} << crush_sh;
    assign crush_t      = ({1'b0, mag_reg} + crush_half) & crush_mask;
    assign crush_mag    = (crush_t > {1'b0, ONE_MAG}) ? ONE_MAG : crush_t[SAMPLE_WIDTH-1:0];

    // Clip level aligned to the sample's fraction bits
    logic [SAMPLE_WIDTH-1:0] clip_lvl;

    generate
        if (FRAC_W >= CLIP_LEVEL_W)
        begin : g_clip_up
            assign clip_lvl = SAMPLE_WIDTH'(cfg.clip_limit) << (FRAC_W - CLIP_LEVEL_W);
        end
        else
        begin : g_clip_down
            assign clip_lvl = SAMPLE_WIDTH'(cfg.clip_limit >> (CLIP_LEVEL_W - FRAC_W));
        end
    endgenerate

    // Input sample to sign and magnitude, phase select
    logic                    in_accept;
    logic                    in_neg;
    logic [SAMPLE_WIDTH-1:0] in_mag;
    logic [PHASE_W-1:0]      in_phase;
    logic                    ring_active;
    logic                    out_free;

    assign in_accept   = sample_chan.valid && (state_reg == S_IDLE);
    assign in_neg      = sample_chan.sample_in[SAMPLE_WIDTH-1];
    assign in_mag      = in_neg ? SAMPLE_WIDTH'(-sample_chan.sample_in)
                                : SAMPLE_WIDTH'(sample_chan.sample_in);
    assign in_phase    = sample_chan.first_sample ? '0 : phase_reg;
    assign ring_active = (cfg.ring_mix != '0) && (cfg.carrier_step != '0);
    assign out_free    = !out_valid_reg || result_chan.ready;

    // Sequencer and datapath
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        ph_next        = ph_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        rom_addr_next  = rom_addr_reg;
        cm_next        = cm_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mul_start      = 1'b0;
        mul_mcand      = COEF_MAG_W'(gain_abs);

        // result taken
        if (out_valid_reg && result_chan.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    ph_next    = in_phase;
                    phase_next = in_phase + cfg.carrier_step;
                    mag_next   = in_mag;
                    neg_next   = in_neg;
                    if (!cfg.effects_enable)
                    begin
                        state_next = S_DONE;
                    end
                    else if (ring_active)
                    begin
                        state_next = S_ADDR;
                    end
                    else
                    begin
                        state_next = S_CRUSH;
                    end
                end
            end
            S_ADDR:
            begin
                // odd quadrants read the table backwards
                rom_addr_next = ph_reg[30] ? ROM_AW'(SINE_TABLE_DEPTH) - ROM_AW'(idx)
                                           : ROM_AW'(idx);
                state_next    = S_ROM;
            end
            S_ROM:
            begin
                state_next = S_COEF;
            end
            S_COEF:
            begin
                cm_next    = carrier_val * $signed({1'b0, mix_eff});
                state_next = S_ABS;
            end
            S_ABS:
            begin
                mul_start  = 1'b1;
                mul_mcand  = coef_abs[COEF_MAG_W-1:0];
                neg_next   = neg_reg ^ coef_neg;
                state_next = S_RMUL;
            end
            S_RMUL:
            begin
                if (!mul_busy)
                begin
                    mag_next   = ring_mag;
                    state_next = S_CRUSH;
                end
            end
            S_CRUSH:
            begin
                if (crush_active)
                begin
                    mag_next = crush_mag;
                end
                state_next = S_CLIP;
            end
            S_CLIP:
            begin
                if (cfg.clip_enable && (mag_reg > clip_lvl))
                begin
                    mag_next = clip_lvl;
                end
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                mul_start  = 1'b1;
                neg_next   = neg_reg ^ gain_neg;
                state_next = S_GMUL;
            end
            S_GMUL:
            begin
                if (!mul_busy)
                begin
                    mag_next   = gain_mag;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // final saturation to [-1, 1 - lsb]
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (!neg_reg && (mag_reg >= ONE_MAG))
                    begin
                        out_data_next = MAX_POS;
                    end
                    else if (neg_reg)
                    begin
                        out_data_next = SAMPLE_WIDTH'(-mag_reg);
                    end
                    else
                    begin
                        out_data_next = mag_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ph_reg       <= ph_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        rom_addr_reg <= rom_addr_next;
        cm_reg       <= cm_next;
        out_data_reg <= out_data_next;
    end

    // Channel outputs
    assign sample_chan.ready      = (state_reg == S_IDLE);
    assign result_chan.valid      = out_valid_reg;
    assign result_chan.sample_out = $signed(out_data_reg);

endmodule

// ===== rtl/vec_checker.sv =====
// ---------------------------------------------------------------------------
// vec_checker
// Port-level checks of the voice effect chain, bound to the top level.
// ---------------------------------------------------------------------------
`include "voice_effect_chain_unit_assert.svh"

module vec_checker #(
    parameter int SAMPLE_WIDTH = 16
)
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [SAMPLE_WIDTH-1:0] out_data
);

    // Stalled result stays offered
    `VEC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // Stalled result payload holds
    `VEC_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed while stalled")

    // One sample in flight: ready drops after a request is taken
    `VEC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second request taken while busy")

    // A fresh result always coincides with the block being free again
    `VEC_ASSERT_SAME(a_done_to_idle, $rose(out_valid), in_ready, "result issued while still busy")

endmodule

bind voice_effect_chain_unit vec_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_vec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample_chan.valid),
    .in_ready  (sample_chan.ready),
    .out_valid (result_chan.valid),
    .out_ready (result_chan.ready),
    .out_data  (result_chan.sample_out)
);

// ===== bench/voice_effect_chain_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// voice_effect_chain_unit_tb
// Self-checking bench for the voice effect chain. A directed table covers
// pass-through, sample extremes, clip/gain/crush corners and carrier
// quadrants. Randomized settings with random sample streams follow.
// Every sample_out is checked against a literal or a bit-exact predictor.
// ---------------------------------------------------------------------------
module voice_effect_chain_unit_tb;
    import vec_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int SAMPLE_W       = 16;
    localparam int SINE_DEPTH     = 1024;
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_ITEMS    = 125;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 16'sh8000;

    // Named settings used by the directed table
    typedef enum logic [2:0] {
        CFG_RESET,
        CFG_PLAIN,
        CFG_CLIP_ZERO,
        CFG_GAIN_MIN,
        CFG_CRUSH_ONE,
        CFG_RING_FULL,
        CFG_RING_MIXED
    } dir_cfg_t;

    typedef struct packed {
        dir_cfg_t                    cfg_sel;
        logic signed [SAMPLE_W-1:0]  smp;
        logic                        first;
        logic                        lit_valid;
        logic signed [SAMPLE_W-1:0]  lit;
    } stim_row_t;

    localparam int DIRECTED_COUNT = 24;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // chain off: samples pass unchanged
        '{CFG_RESET,      16'sd0,      1'b1, 1'b1, 16'sd0},
        '{CFG_RESET,      SMP_MIN,     1'b0, 1'b1, SMP_MIN},
        '{CFG_RESET,      SMP_MAX,     1'b0, 1'b1, SMP_MAX},
        '{CFG_RESET,      -16'sd1,     1'b0, 1'b1, -16'sd1},
        // chain on, unity gain, nothing else
        '{CFG_PLAIN,      SMP_MAX,     1'b0, 1'b1, SMP_MAX},
        '{CFG_PLAIN,      SMP_MIN,     1'b0, 1'b1, SMP_MIN},
        '{CFG_PLAIN,      16'sd1,      1'b0, 1'b1, 16'sd1},
        // clip to zero level
        '{CFG_CLIP_ZERO,  SMP_MAX,     1'b0, 1'b1, 16'sd0},
        '{CFG_CLIP_ZERO,  SMP_MIN,     1'b0, 1'b1, 16'sd0},
        // gain of -8 saturates both ways
        '{CFG_GAIN_MIN,   SMP_MAX,     1'b0, 1'b1, SMP_MIN},
        '{CFG_GAIN_MIN,   SMP_MIN,     1'b0, 1'b1, SMP_MAX},
        '{CFG_GAIN_MIN,   16'sd0,      1'b0, 1'b1, 16'sd0},
        // one-bit crush: half rounds away from zero
        '{CFG_CRUSH_ONE,  16'sd16384,  1'b0, 1'b1, SMP_MAX},
        '{CFG_CRUSH_ONE,  16'sd16383,  1'b0, 1'b1, 16'sd0},
        '{CFG_CRUSH_ONE,  -16'sd16384, 1'b0, 1'b1, SMP_MIN},
        '{CFG_CRUSH_ONE,  -16'sd16383, 1'b0, 1'b1, 16'sd0},
        // fully wet ring mod, quarter-turn carrier: sine is zero at phase 0
        '{CFG_RING_FULL,  16'sd20000,  1'b1, 1'b1, 16'sd0},
        '{CFG_RING_FULL,  16'sd20000,  1'b0, 1'b0, 16'sd0},
        '{CFG_RING_FULL,  SMP_MIN,     1'b0, 1'b0, 16'sd0},
        '{CFG_RING_FULL,  SMP_MAX,     1'b0, 1'b0, 16'sd0},
        // half wet, wrapping carrier, crush setting out of range (off), max gain
        '{CFG_RING_MIXED, SMP_MAX,     1'b1, 1'b0, 16'sd0},
        '{CFG_RING_MIXED, SMP_MIN,     1'b0, 1'b0, 16'sd0},
        '{CFG_RING_MIXED, 16'sd12345,  1'b0, 1'b0, 16'sd0},
        '{CFG_RING_MIXED, -16'sd7,     1'b0, 1'b0, 16'sd0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    vec_in_if  #(.SAMPLE_WIDTH(SAMPLE_W)) sample_if ();
    vec_out_if #(.SAMPLE_WIDTH(SAMPLE_W)) result_if ();

    voice_effect_chain_unit #(
        .SINE_TABLE_DEPTH (SINE_DEPTH),
        .SAMPLE_WIDTH     (SAMPLE_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_chan (sample_if),
        .result_chan (result_if),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor state: mirrored settings, carrier phase and sine table
    vec_cfg_t           chain_cfg;
    logic [PHASE_W-1:0] carrier_phase;
    int                 quarter_sine [0:SINE_DEPTH];

    logic signed [SAMPLE_W-1:0] awaited_outputs [$];

    int  error_count;
    int  items_sent;
    int  results_seen;
    int  settings_loaded;
    int  utterances;
    int  quiet_cycles;
    bit  hold_pending;
    bit  steady_flow;

    // Quarter-wave entry: Q30 Taylor series to x^13, scaled to 32767
    function automatic int sine_entry(int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] e;
        longint      acc;
        x    = 64'(k) * HALF_PI_Q30 / 64'(SINE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        e = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (e > 64'd32767)
            e = 64'd32767;
        return int'(e);
    endfunction

    // Divide by 2^sh, rounding half away from zero
    function automatic longint round_shift(longint v, int sh);
        logic [63:0] mag;
        if (sh == 0)
            return v;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint limit_to(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Carrier value: quadrant picks table direction and sign
    function automatic longint carrier_value(logic [PHASE_W-1:0] ph);
        int idx;
        idx = int'((64'(ph[29:0]) * 64'(SINE_DEPTH)) >> 30);
        case (ph[31:30])
            2'd0:    return longint'(quarter_sine[idx]);
            2'd1:    return longint'(quarter_sine[SINE_DEPTH - idx]);
            2'd2:    return -longint'(quarter_sine[idx]);
            default: return -longint'(quarter_sine[SINE_DEPTH - idx]);
        endcase
    endfunction

    // Expected output for one accepted sample; advances the carrier phase
    function automatic logic signed [SAMPLE_W-1:0] process_sample(
        logic signed [SAMPLE_W-1:0] smp, logic first);
        longint             x;
        longint             m;
        longint             coef;
        logic [PHASE_W-1:0] ph;
        int                 s;
        x = smp;
        if (first)
            carrier_phase = '0;
        ph            = carrier_phase;
        carrier_phase = carrier_phase + chain_cfg.carrier_step;
        if (chain_cfg.effects_enable)
        begin
            // ring modulation, mix saturates at fully wet
            if (chain_cfg.ring_mix != 0 && chain_cfg.carrier_step != 0)
            begin
                m = longint'(chain_cfg.ring_mix);
                if (m > 32768)
                    m = 32768;
                coef = 32768 * (32768 - m) + carrier_value(ph) * m;
                x    = round_shift(x * coef, RING_FRAC);
            end
            // bit-depth reduction, 16 and above means off
            if (chain_cfg.crush_bits != 0 && chain_cfg.crush_bits < 24)
            begin
                s = SAMPLE_W - int'(chain_cfg.crush_bits);
                if (s > 0)
                begin
                    x = round_shift(x, s) * (longint'(1) << s);
                    x = limit_to(x, -32768, 32768);
                end
            end
            if (chain_cfg.clip_enable)
                x = limit_to(x, -longint'(chain_cfg.clip_limit),
                             longint'(chain_cfg.clip_limit));
            x = round_shift(x * longint'($signed(chain_cfg.gain_factor)), GAIN_FRAC);
            x = limit_to(x, -32768, 32768);
        end
        x = limit_to(x, -32768, 32767);
        return x[SAMPLE_W-1:0];
    endfunction

    function automatic vec_cfg_t directed_config(dir_cfg_t sel);
        vec_cfg_t c;
        c = '{effects_enable: 1'b1, carrier_step: '0, ring_mix: '0, crush_bits: '0,
              clip_enable: 1'b0, clip_limit: CLIP_LEVEL_RESET, gain_factor: GAIN_RESET};
        case (sel)
            CFG_RESET:
                c.effects_enable = 1'b0;
            CFG_CLIP_ZERO:
            begin
                c.clip_enable = 1'b1;
                c.clip_limit  = '0;
            end
            CFG_GAIN_MIN:
                c.gain_factor = 16'sh8000;
            CFG_CRUSH_ONE:
                c.crush_bits = 5'd1;
            CFG_RING_FULL:
            begin
                c.carrier_step = 32'h4000_0000;
                c.ring_mix     = 16'hFFFF;
                c.crush_bits   = 5'd31;
            end
            CFG_RING_MIXED:
            begin
                c.carrier_step = 32'hFFFF_FFFF;
                c.ring_mix     = 16'd16384;
                c.crush_bits   = 5'd23;
                c.clip_enable  = 1'b1;
                c.clip_limit   = 15'h7FFF;
                c.gain_factor  = 16'sh7FFF;
            end
            default:
                ;
        endcase
        return c;
    endfunction

    // Random settings with weight on the corners
    function automatic vec_cfg_t draw_settings();
        vec_cfg_t c;
        c.effects_enable = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 5))
            0:       c.carrier_step = '0;
            1:       c.carrier_step = 32'hFFFF_FFFF;
            2:       c.carrier_step = $urandom_range(1, 32'h0100_0000);
            default: c.carrier_step = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0:       c.ring_mix = '0;
            1:       c.ring_mix = RING_MIX_FULL;
            2:       c.ring_mix = 16'($urandom_range(32769, 65535));
            default: c.ring_mix = 16'($urandom_range(1, 32767));
        endcase
        case ($urandom_range(0, 4))
            0:       c.crush_bits = '0;
            1:       c.crush_bits = 5'($urandom_range(24, 31));
            default: c.crush_bits = 5'($urandom_range(1, 23));
        endcase
        c.clip_enable = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
            0:       c.clip_limit = '0;
            1:       c.clip_limit = 15'h7FFF;
            default: c.clip_limit = 15'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       c.gain_factor = GAIN_RESET;
            1:       c.gain_factor = 16'sh8000;
            2:       c.gain_factor = 16'sh7FFF;
            default: c.gain_factor = 16'($urandom);
        endcase
        return c;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 15))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2:       return 16'($urandom_range(0, 3)) - 16'sd2;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // One register write per cycle; block is idle here
    task automatic write_reg(vec_reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    task automatic load_settings(vec_cfg_t c);
        write_reg(REG_EFFECTS_ENABLE, CFG_DATA_W'(c.effects_enable));
        write_reg(REG_CARRIER_STEP,   c.carrier_step);
        write_reg(REG_RING_MIX,       CFG_DATA_W'(c.ring_mix));
        write_reg(REG_CRUSH_BITS,     CFG_DATA_W'(c.crush_bits));
        write_reg(REG_CLIP_ENABLE,    CFG_DATA_W'(c.clip_enable));
        write_reg(REG_CLIP_LEVEL,     CFG_DATA_W'(c.clip_limit));
        write_reg(REG_OUTPUT_GAIN,    CFG_DATA_W'($unsigned(c.gain_factor)));
        @(posedge clk);
        cfg_write <= 1'b0;
        chain_cfg = c;
        settings_loaded++;
    endtask

    // Offer one sample and hold it until accepted; valid stays high on return
    task automatic offer_sample(logic signed [SAMPLE_W-1:0] smp, logic first,
                                bit lit_valid, logic signed [SAMPLE_W-1:0] lit);
        logic signed [SAMPLE_W-1:0] predicted;
        sample_if.valid        <= 1'b1;
        sample_if.sample_in    <= smp;
        sample_if.first_sample <= first;
        do
            @(posedge clk);
        while (!sample_if.ready);
        predicted = process_sample(smp, first);
        awaited_outputs.insert(awaited_outputs.size(), lit_valid ? lit : predicted);
        items_sent++;
        if (first)
            utterances++;
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (awaited_outputs.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random ready runs and stalls, long hold-off on request
    initial
    begin : result_sink
        int r;
        result_if.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (steady_flow)
            begin
                result_if.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                result_if.ready <= 1'b1;
                r = $urandom_range(0, 99);
                repeat ((r < 10) ? $urandom_range(60, 200) : $urandom_range(1, 16))
                    @(posedge clk);
                result_if.ready <= 1'b0;
                r = $urandom_range(0, 99);
                if (r < 60)
                    @(posedge clk);
                else if (r < 92)
                    repeat ($urandom_range(2, 5)) @(posedge clk);
                else
                    repeat ($urandom_range(20, 60)) @(posedge clk);
            end
        end
    end

    // Compare each accepted result against the oldest expectation
    always @(posedge clk)
    begin : result_check
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            results_seen++;
            if (awaited_outputs.size() == 0)
            begin
                error_count++;
                $error("sample_out: expected none, actual %0d", result_if.sample_out);
            end
            else
            begin
                want = awaited_outputs.pop_front();
                if (result_if.sample_out !== want)
                begin
                    error_count++;
                    $error("sample_out: expected %0d, actual %0d",
                           want, result_if.sample_out);
                end
            end
        end
    end

    // Stall watchdog: no request moved and no register written for too long
    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (sample_if.valid && sample_if.ready)
            || (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int       cur_sel;
        bit       pressure;
        vec_cfg_t c;
        rst_n                  = 1'b0;
        cfg_write              = 1'b0;
        cfg_index              = REG_EFFECTS_ENABLE;
        cfg_data               = '0;
        sample_if.valid        = 1'b0;
        sample_if.sample_in    = '0;
        sample_if.first_sample = 1'b0;
        hold_pending           = 1'b0;
        steady_flow            = 1'b0;
        error_count            = 0;
        items_sent             = 0;
        results_seen           = 0;
        settings_loaded        = 0;
        utterances             = 0;
        carrier_phase          = '0;
        chain_cfg              = directed_config(CFG_RESET);
        for (int k = 0; k <= SINE_DEPTH; k++)
            quarter_sine[k] = sine_entry(k);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; settings change only with the block drained
        cur_sel = -1;
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            if (int'(DIRECTED_ROWS[i].cfg_sel) != cur_sel)
            begin
                pause_sender(1);
                wait_drained();
                load_settings(directed_config(DIRECTED_ROWS[i].cfg_sel));
                cur_sel = int'(DIRECTED_ROWS[i].cfg_sel);
            end
            offer_sample(DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].first,
                         DIRECTED_ROWS[i].lit_valid, DIRECTED_ROWS[i].lit);
            pause_sender(sender_gap());
        end

        // Random phases: corner settings first, then drawn settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            pause_sender(1);
            steady_flow = 1'b0;
            wait_drained();
            if (p == 0)
                c = '{effects_enable: 1'b1, carrier_step: 32'hFFFF_FFFF,
                      ring_mix: RING_MIX_FULL, crush_bits: 5'd23, clip_enable: 1'b1,
                      clip_limit: 15'h7FFF, gain_factor: 16'sh7FFF};
            else if (p == 1)
                c = '{effects_enable: 1'b1, carrier_step: 32'd1, ring_mix: 16'd1,
                      crush_bits: 5'd1, clip_enable: 1'b0, clip_limit: '0,
                      gain_factor: 16'sh8000};
            else
                c = draw_settings();
            load_settings(c);
            // phase 2 backs up the block behind a long output hold-off
            pressure = (p == 2);
            if (pressure)
                hold_pending = 1'b1;
            steady_flow = (p == 5);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                offer_sample(draw_sample(), (i == 0) || ($urandom_range(0, 31) == 0),
                             1'b0, '0);
                if (!pressure && !steady_flow)
                    pause_sender(sender_gap());
            end
        end

        pause_sender(1);
        steady_flow = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_outputs.size() != 0)
        begin
            error_count++;
            $error("sample_out: %0d expected results never arrived",
                   awaited_outputs.size());
        end

        $display("Covered %0d samples (%0d directed) in %0d utterances over %0d settings.",
                 items_sent, DIRECTED_COUNT, utterances, settings_loaded);
        $display("Checked %0d results, %0d mismatches, with output hold-off and steady flow.",
                 results_seen, error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
